[rtl/ecl_pkg.sv]
// Shared types, codes and helper functions of the expert cache replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package ecl_pkg;

	localparam int NUM_EXPERTS = 64;

	localparam logic [1:0] KIND_ACT = 2'd0;
	localparam logic [1:0] KIND_SIZE = 2'd1;
	localparam logic [1:0] KIND_COUNT = 2'd2;
	localparam logic [1:0] KIND_REQ = 2'd3;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_CAPACITY = 2'd1;
	localparam logic [1:0] CFG_LAYERS = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  layer;
		logic [5:0]  expert;
		logic [31:0] value;
		logic [63:0] active_mask;
	} item_t;

	typedef struct packed {
		logic [6:0]  hits;
		logic [6:0]  misses;
		logic [6:0]  evictions;
		logic [37:0] bytes_added;
		logic [6:0]  resident_count;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [47:0] bytes_total;
	} result_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic cap;
		logic cnt;
		logic scan_next;
		logic hit;
		logic sz_rd;
		logic srch_init;
		logic srch;
		logic evict;
		logic add;
		logic wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic cnt_last;
		logic req_en;
		logic e_end;
		logic e_act;
		logic e_res;
		logic occ_full;
		logic srch_done;
		logic out_free;
	} stat_t;

	function automatic logic [3:0] popcnt8(input logic [7:0] v);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

	function automatic logic [63:0] below(input logic [6:0] n);
		logic [63:0] m;
		for (int i = 0; i < NUM_EXPERTS; i++) begin
			m[i] = 7'(i) < n;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[rtl/ecl_if.sv]
// Valid/ready channel interfaces for input items and result words.
`timescale 1ns / 1ps
`default_nettype none
interface ecl_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  layer;
	logic [5:0]  expert;
	logic [31:0] value;
	logic [63:0] active_mask;
	modport source(output valid, kind, layer, expert, value, active_mask, input ready);
	modport sink(input valid, kind, layer, expert, value, active_mask, output ready);
endinterface

interface ecl_result_if;
	logic        valid;
	logic        ready;
	logic [6:0]  hits;
	logic [6:0]  misses;
	logic [6:0]  evictions;
	logic [37:0] bytes_added;
	logic [6:0]  resident_count;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [47:0] bytes_total;
	modport source(output valid, hits, misses, evictions, bytes_added, resident_count,
		hit_total, miss_total, bytes_total, input ready);
	modport sink(input valid, hits, misses, evictions, bytes_added, resident_count,
		hit_total, miss_total, bytes_total, output ready);
endinterface
`default_nettype wire

[rtl/ecl_ctrl.sv]
// Sequencer of the replacement unit: clearing pass, row count, expert scan, victim search.
`timescale 1ns / 1ps
`default_nettype none
module ecl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire ecl_pkg::stat_t stat,
	output ecl_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_CAP, S_CNT, S_SCAN, S_SRCH, S_ADD, S_WR, S_OUT
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		item_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_CAP;
			end
			S_CAP: begin
				cmd.cap = 1'b1;
				state_d = S_CNT;
			end
			S_CNT: begin
				cmd.cnt = 1'b1;
				if (stat.cnt_last) state_d = stat.req_en ? S_SCAN : S_WR;
			end
			S_SCAN: begin
				if (stat.e_end) begin
					state_d = S_WR;
				end else if (!stat.e_act) begin
					cmd.scan_next = 1'b1;
				end else if (stat.e_res) begin
					cmd.scan_next = 1'b1;
					cmd.hit = 1'b1;
				end else begin
					cmd.sz_rd = 1'b1;
					cmd.srch_init = 1'b1;
					state_d = stat.occ_full ? S_SRCH : S_ADD;
				end
			end
			S_SRCH: begin
				cmd.srch = 1'b1;
				if (stat.srch_done) begin
					cmd.evict = 1'b1;
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_SCAN;
			end
			S_WR: begin
				cmd.wr = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

endmodule
`default_nettype wire

[rtl/ecl_dp.sv]
// Datapath of the replacement unit: tables, working row, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module ecl_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ecl_pkg::cmd_t   cmd,
	output ecl_pkg::stat_t       stat,
	input  wire ecl_pkg::item_t  item,
	output ecl_pkg::result_t     result,
	output logic                 result_valid,
	input  wire logic            result_ready,
	input  wire logic            wr_en,
	input  wire logic [1:0]      wr_index,
	input  wire logic [6:0]      wr_data
);

	logic [63:0] res_mem [64];
	logic [6:0]  lec_mem [64];
	logic [31:0] act_mem [4096];
	logic [31:0] size_mem [4096];

	logic [63:0] res_rd_q;
	logic [6:0]  lec_rd_q;
	logic [31:0] act_rd_q, size_rd_q;

	logic [1:0]  kind_q;
	logic [5:0]  layer_q, expert_q;
	logic [31:0] value_q;
	logic [63:0] mask_q, row_q;
	logic [6:0]  n_q, occ_q, e_q, v_q;
	logic        req_en_q;
	logic [2:0]  c_q;
	logic        vld_s1, cand_s1;
	logic [5:0]  vtag_s1, best_v_q;
	logic        found_q;
	logic [31:0] best_a_q;
	logic [6:0]  hits_q, miss_q, evict_q;
	logic [37:0] bytes_q;
	logic [31:0] hit_tot_q, miss_tot_q;
	logic [47:0] byte_tot_q;
	logic [11:0] clr_q;
	logic        en_q;
	logic [6:0]  cap_q, lin_q;
	logic        out_valid_q;
	ecl_pkg::result_t out_q;

	logic [6:0]  n_cap;
	logic [63:0] vm;
	logic        is_count, act_rd_en;

	assign is_count = kind_q == ecl_pkg::KIND_COUNT;
	assign n_cap = is_count ? ((value_q > 32'd64) ? 7'd64 : value_q[6:0]) : lec_rd_q;
	assign vm = ecl_pkg::below(n_cap);
	assign act_rd_en = cmd.srch && (v_q < n_q);

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			res_mem[clr_q[5:0]] <= '0;
			lec_mem[clr_q[5:0]] <= '0;
			act_mem[clr_q] <= '0;
			size_mem[clr_q] <= '0;
		end else if (cmd.wr) begin
			if (is_count || req_en_q) res_mem[layer_q] <= row_q;
			if (is_count) lec_mem[layer_q] <= n_q;
			if (kind_q == ecl_pkg::KIND_ACT) act_mem[{layer_q, expert_q}] <= value_q;
			if (kind_q == ecl_pkg::KIND_SIZE) size_mem[{layer_q, expert_q}] <= value_q;
		end
		if (cmd.rd) begin
			res_rd_q <= res_mem[layer_q];
			lec_rd_q <= lec_mem[layer_q];
		end
		if (cmd.sz_rd) size_rd_q <= size_mem[{layer_q, e_q[5:0]}];
		if (act_rd_en) act_rd_q <= act_mem[{layer_q, v_q[5:0]}];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.kind;
			layer_q <= item.layer;
			expert_q <= item.expert;
			value_q <= item.value;
			mask_q <= item.active_mask;
		end else if (cmd.cap) begin
			mask_q <= mask_q & vm;
		end
		if (cmd.out_load) begin
			out_q.hits <= hits_q;
			out_q.misses <= miss_q;
			out_q.evictions <= evict_q;
			out_q.bytes_added <= bytes_q;
			out_q.resident_count <= occ_q;
			out_q.hit_total <= hit_tot_q;
			out_q.miss_total <= miss_tot_q;
			out_q.bytes_total <= byte_tot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			en_q <= 1'b0;
			cap_q <= '0;
			lin_q <= '0;
			out_valid_q <= 1'b0;
			hit_tot_q <= '0;
			miss_tot_q <= '0;
			byte_tot_q <= '0;
			row_q <= '0;
			n_q <= '0;
			occ_q <= '0;
			e_q <= '0;
			v_q <= '0;
			c_q <= '0;
			req_en_q <= 1'b0;
			vld_s1 <= 1'b0;
			cand_s1 <= 1'b0;
			vtag_s1 <= '0;
			found_q <= 1'b0;
			best_a_q <= '0;
			best_v_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			evict_q <= '0;
			bytes_q <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + 12'd1;
			if (wr_en) begin
				case (wr_index)
					ecl_pkg::CFG_ENABLE:   en_q <= wr_data[0];
					ecl_pkg::CFG_CAPACITY: cap_q <= wr_data;
					ecl_pkg::CFG_LAYERS:   lin_q <= wr_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				hits_q <= '0;
				miss_q <= '0;
				evict_q <= '0;
				bytes_q <= '0;
				e_q <= '0;
			end
			if (cmd.cap) begin
				n_q <= n_cap;
				row_q <= res_rd_q & (is_count ? vm : '1);
				req_en_q <= (kind_q == ecl_pkg::KIND_REQ) && en_q && (cap_q != 7'd0)
					&& ({1'b0, layer_q} < lin_q) && (n_cap != 7'd0);
				occ_q <= '0;
				c_q <= '0;
			end
			if (cmd.cnt) begin
				occ_q <= occ_q + {3'd0, ecl_pkg::popcnt8(row_q[{c_q, 3'b000} +: 8])};
				c_q <= c_q + 3'd1;
			end
			if (cmd.scan_next) e_q <= e_q + 7'd1;
			if (cmd.hit) hits_q <= hits_q + 7'd1;
			if (cmd.srch_init) begin
				v_q <= '0;
				found_q <= 1'b0;
				vld_s1 <= 1'b0;
			end
			if (cmd.srch) begin
				if (v_q < n_q) begin
					vld_s1 <= 1'b1;
					cand_s1 <= row_q[v_q[5:0]] & ~mask_q[v_q[5:0]];
					vtag_s1 <= v_q[5:0];
					v_q <= v_q + 7'd1;
				end else begin
					vld_s1 <= 1'b0;
				end
				if (vld_s1 && cand_s1 && (!found_q || (act_rd_q < best_a_q))) begin
					found_q <= 1'b1;
					best_a_q <= act_rd_q;
					best_v_q <= vtag_s1;
				end
			end
			if (cmd.evict && found_q) begin
				row_q[best_v_q] <= 1'b0;
				occ_q <= occ_q - 7'd1;
				evict_q <= evict_q + 7'd1;
			end
			if (cmd.add) begin
				row_q[e_q[5:0]] <= 1'b1;
				occ_q <= occ_q + 7'd1;
				miss_q <= miss_q + 7'd1;
				bytes_q <= bytes_q + {6'd0, size_rd_q};
				e_q <= e_q + 7'd1;
			end
			if (cmd.wr && req_en_q) begin
				hit_tot_q <= hit_tot_q + {25'd0, hits_q};
				miss_tot_q <= miss_tot_q + {25'd0, miss_q};
				byte_tot_q <= byte_tot_q + {10'd0, bytes_q};
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.clr_last = &clr_q;
		stat.cnt_last = c_q == 3'd7;
		stat.req_en = req_en_q;
		stat.e_end = e_q >= n_q;
		stat.e_act = mask_q[e_q[5:0]];
		stat.e_res = row_q[e_q[5:0]];
		stat.occ_full = occ_q >= cap_q;
		stat.srch_done = (v_q >= n_q) && !vld_s1;
		stat.out_free = !out_valid_q || result_ready;
	end

	assign result = out_q;
	assign result_valid = out_valid_q;

endmodule
`default_nettype wire

[rtl/expert_cache_lfu_policy_unit.sv]
// Top level of the expert cache least-frequently-used replacement unit.
// After reset the unit runs a clearing pass over its tables and takes no item until it
// ends; configuration writes are taken throughout. Each item then gives one result word.
// Every item first reads the layer's rows and counts its residency row eight bits at a
// time. A served request then scans each expert below the layer's expert count, loads
// each active expert that is not resident, and for each load into a full layer runs a
// victim search over the layer's experts through the single read port of the activation
// table. The next item is accepted while the previous result still waits.
`timescale 1ns / 1ps
`default_nettype none
module expert_cache_lfu_policy_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ecl_item_if.sink    item,
	ecl_result_if.source result,
	input  wire logic   wr_en,
	input  wire logic [1:0] wr_index,
	input  wire logic [6:0] wr_data
);

	ecl_pkg::cmd_t    cmd;
	ecl_pkg::stat_t   stat;
	ecl_pkg::item_t   item_w;
	ecl_pkg::result_t res_w;
	logic             item_ready, res_valid;

	assign item_w.kind = item.kind;
	assign item_w.layer = item.layer;
	assign item_w.expert = item.expert;
	assign item_w.value = item.value;
	assign item_w.active_mask = item.active_mask;
	assign item.ready = item_ready;

	ecl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	ecl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item_w),
		.result       (res_w),
		.result_valid (res_valid),
		.result_ready (result.ready),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	assign result.valid = res_valid;
	assign result.hits = res_w.hits;
	assign result.misses = res_w.misses;
	assign result.evictions = res_w.evictions;
	assign result.bytes_added = res_w.bytes_added;
	assign result.resident_count = res_w.resident_count;
	assign result.hit_total = res_w.hit_total;
	assign result.miss_total = res_w.miss_total;
	assign result.bytes_total = res_w.bytes_total;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !item_ready)
		else $error("item taken during clearing pass");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!res_valid || result.ready))
		else $error("result word overwritten before it was taken");

	a_resident_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_w.resident_count <= 7'd64))
		else $error("resident count beyond expert count");

	a_hits_plus_misses: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res_w.hits} + {1'b0, res_w.misses} <= 8'd64))
		else $error("more hits and misses than experts");

endmodule
`default_nettype wire
